@@ sv/pcx_pkg.sv @@
// Shared types and constants for the PCX run-length image decoder.
// No dependencies; imported by pcx_ctrl, pcx_dp and the top level.
package pcx_pkg;

    localparam int HEADER_BYTES_DEF = 128;
    localparam int OFS_W            = 8;
    localparam int PIX_W            = 8;
    localparam int DIM_W            = 17;
    localparam int CNT_W            = 33;
    localparam int RUN_W            = 6;
    localparam int M_TDATA_W        = 48;

    localparam logic [OFS_W-1:0] OFS_WIDTH_LO  = 8'd8;
    localparam logic [OFS_W-1:0] OFS_WIDTH_HI  = 8'd9;
    localparam logic [OFS_W-1:0] OFS_HEIGHT_LO = 8'd10;
    localparam logic [OFS_W-1:0] OFS_HEIGHT_HI = 8'd11;
    localparam logic [PIX_W-1:0] RUN_MIN       = 8'd192;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_MUL,
        ST_DATA,
        ST_RUNVAL,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic hdr_byte;
        logic mul_load;
        logic run_load;
        logic val_load;
        logic emit_byte;
        logic emit_run;
    } cmd_t;

    typedef struct packed {
        logic hdr_done;
        logic dims_zero;
        logic run_code;
        logic px_one;
        logic px_zero;
        logic run_end;
        logic out_free;
    } sts_t;

endpackage

@@ sv/pcx_ctrl.sv @@
// Controller state machine of the PCX decoder: header, multiply, data, run value, run, done.
// Depends on pcx_pkg; drives the pcx_dp datapath through cmd_t.
module pcx_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tlast,
    output logic          s_tready,
    input  pcx_pkg::sts_t sts,
    output pcx_pkg::cmd_t cmd
);
    import pcx_pkg::*;

    state_t state_reg, state_next;
    logic   last_pend_reg, last_pend_next;
    logic   acc;

    assign acc = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HEADER;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_pend_reg <= last_pend_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        last_pend_next = last_pend_reg;
        case (state_reg)
            ST_HEADER: begin
                if (acc) begin
                    if (s_tlast) begin
                        state_next = ST_HEADER;
                    end else if (sts.hdr_done) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                state_next = sts.dims_zero ? ST_DONE : ST_DATA;
            end
            ST_DATA: begin
                if (acc) begin
                    if (s_tlast) begin
                        state_next = ST_HEADER;
                    end else if (sts.run_code) begin
                        state_next = ST_RUNVAL;
                    end else if (sts.px_one) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUNVAL: begin
                if (acc) begin
                    state_next     = ST_RUN;
                    last_pend_next = s_tlast;
                end
            end
            ST_RUN: begin
                if (sts.run_end) begin
                    last_pend_next = 1'b0;
                    if (last_pend_reg) begin
                        state_next = ST_HEADER;
                    end else begin
                        state_next = sts.px_zero ? ST_DONE : ST_DATA;
                    end
                end
            end
            ST_DONE: begin
                if (acc && s_tlast) begin
                    state_next = ST_HEADER;
                end
            end
            default: begin
                state_next     = ST_HEADER;
                last_pend_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_HEADER: begin
                s_tready     = 1'b1;
                cmd.hdr_byte = acc;
                cmd.clear    = acc & s_tlast;
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
            end
            ST_DATA: begin
                s_tready      = sts.out_free;
                cmd.run_load  = acc & sts.run_code;
                cmd.emit_byte = acc & ~sts.run_code;
                cmd.clear     = acc & s_tlast;
            end
            ST_RUNVAL: begin
                s_tready     = 1'b1;
                cmd.val_load = acc;
            end
            ST_RUN: begin
                cmd.emit_run = ~sts.run_end & sts.out_free;
                cmd.clear    = sts.run_end & last_pend_reg;
            end
            ST_DONE: begin
                s_tready  = 1'b1;
                cmd.clear = acc & s_tlast;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/pcx_dp.sv @@
// Datapath of the PCX decoder: header counters, dimensions, pixel and run
// counters, and the output register. Depends on pcx_pkg; driven by pcx_ctrl.
module pcx_dp #(
    parameter int HEADER_BYTES = pcx_pkg::HEADER_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [pcx_pkg::PIX_W-1:0]           data_byte,
    input  pcx_pkg::cmd_t                       cmd,
    output pcx_pkg::sts_t                       sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [pcx_pkg::PIX_W-1:0]           pixel,
    output logic [pcx_pkg::DIM_W-1:0]           image_width,
    output logic [pcx_pkg::DIM_W-1:0]           image_height,
    output logic                                last_pixel
);
    import pcx_pkg::*;

    localparam logic [OFS_W-1:0] HDR_LAST = OFS_W'(HEADER_BYTES - 1);

    logic [OFS_W-1:0] byte_offset_reg, byte_offset_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [CNT_W-1:0] pixels_left_reg, pixels_left_next;
    logic [RUN_W-1:0] run_length_reg, run_length_next;
    logic [PIX_W-1:0] value_reg, value_next;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pixel_reg, out_pixel_next;
    logic [DIM_W-1:0] out_width_reg, out_width_next;
    logic [DIM_W-1:0] out_height_reg, out_height_next;
    logic             out_last_reg, out_last_next;
    logic [CNT_W-1:0] product;
    logic             emit;

    assign product = CNT_W'(width_reg) * CNT_W'(height_reg);
    assign emit    = cmd.emit_byte | cmd.emit_run;

    assign sts.hdr_done  = (byte_offset_reg == HDR_LAST);
    assign sts.dims_zero = (width_reg == '0) || (height_reg == '0);
    assign sts.run_code  = (data_byte >= RUN_MIN);
    assign sts.px_one    = (pixels_left_reg == CNT_W'(1));
    assign sts.px_zero   = (pixels_left_reg == '0);
    assign sts.run_end   = (run_length_reg == '0) || (pixels_left_reg == '0);
    assign sts.out_free  = ~out_valid_reg | m_tready;

    always_comb begin
        byte_offset_next = byte_offset_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        pixels_left_next = pixels_left_reg;
        run_length_next  = run_length_reg;
        value_next       = value_reg;

        if (cmd.hdr_byte) begin
            byte_offset_next = sts.hdr_done ? '0 : byte_offset_reg + OFS_W'(1);
            case (byte_offset_reg)
                OFS_WIDTH_LO:  width_next  = DIM_W'(data_byte);
                OFS_WIDTH_HI:  width_next  = DIM_W'({data_byte, width_reg[PIX_W-1:0]})
                                             + DIM_W'(1);
                OFS_HEIGHT_LO: height_next = DIM_W'(data_byte);
                OFS_HEIGHT_HI: height_next = DIM_W'({data_byte, height_reg[PIX_W-1:0]})
                                             + DIM_W'(1);
                default: ;
            endcase
        end
        if (cmd.mul_load) begin
            pixels_left_next = product;
        end
        if (cmd.run_load) begin
            run_length_next = data_byte[RUN_W-1:0];
        end
        if (cmd.val_load) begin
            value_next = data_byte;
        end
        if (emit) begin
            pixels_left_next = pixels_left_reg - CNT_W'(1);
        end
        if (cmd.emit_run) begin
            run_length_next = run_length_reg - RUN_W'(1);
        end
        if (cmd.clear) begin
            byte_offset_next = '0;
            width_next       = '0;
            height_next      = '0;
            pixels_left_next = '0;
            run_length_next  = '0;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg & ~m_tready;
        out_pixel_next  = out_pixel_reg;
        out_width_next  = out_width_reg;
        out_height_next = out_height_reg;
        out_last_next   = out_last_reg;
        if (emit) begin
            out_valid_next  = 1'b1;
            out_pixel_next  = cmd.emit_run ? value_reg : data_byte;
            out_width_next  = width_reg;
            out_height_next = height_reg;
            out_last_next   = sts.px_one;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            pixels_left_reg <= '0;
            run_length_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            byte_offset_reg <= byte_offset_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            pixels_left_reg <= pixels_left_next;
            run_length_reg  <= run_length_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg      <= value_next;
        out_pixel_reg  <= out_pixel_next;
        out_width_reg  <= out_width_next;
        out_height_reg <= out_height_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid     = out_valid_reg;
    assign pixel        = out_pixel_reg;
    assign image_width  = out_width_reg;
    assign image_height = out_height_reg;
    assign last_pixel   = out_last_reg;

endmodule

@@ sv/pcx_rle_image_decoder_core.sv @@
// Top level of the PCX run-length image decoder: stream ports, controller
// and datapath. Depends on pcx_pkg, pcx_ctrl and pcx_dp.
//
//   channel | dir | tdata (low bit up)                        | tlast
//   s_      | in  | data_byte[7:0]                            | file_last
//   m_      | out | pixel, image_width, image_height, 6'b0    | last_pixel
//
// Header bytes, literal pixels and run openers are each taken in a single handshake.
// After the last header byte a multiply state loads width * height into the pixel counter.
// A run value byte is taken next; s_tready then stays low while the run's pixels
// leave one per cycle when m_ is free (up to 63) and while the run is closed.
// A stalled m_ side holds s_tready low in the data phase and halts run output.
// aresetn is synchronous, active low, and returns the parser to the header.
module pcx_rle_image_decoder_core #(
    parameter int HEADER_BYTES = pcx_pkg::HEADER_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // data_byte[7:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel[7:0], image_width[24:8], image_height[41:25], zero[47:42]
    output logic [pcx_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);
    import pcx_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic [PIX_W-1:0] pixel;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;

    pcx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcx_dp #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .data_byte    (s_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .pixel        (pixel),
        .image_width  (image_width),
        .image_height (image_height),
        .last_pixel   (m_tlast)
    );

    assign m_tdata = {(M_TDATA_W - PIX_W - 2*DIM_W)'(0), image_height, image_width, pixel};

`ifndef SYNTHESIS
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_byte || cmd.emit_run) |-> sts.out_free)
        else $error("pixel emitted while output register is occupied");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_run |-> !sts.run_end)
        else $error("run pixel emitted past run or image end");

    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.emit_byte && cmd.emit_run))
        else $error("literal and run pixel emitted together");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_byte || cmd.emit_run) && sts.px_one |=> sts.px_zero || $past(cmd.clear))
        else $error("pixel counter not exhausted after last pixel");
`endif

endmodule
